[hw/rtl/pld_pkg.sv]
// Shared types, constants and conversion helpers for the pose/landmark frame decoder.
// No dependencies; imported by pose_landmark_frame_decoder.
package pld_pkg;

  localparam int ID_W              = 29;
  localparam int CNT_W             = 6;
  localparam int CONE_WINDOW_DEF   = 256;
  localparam int CORDIC_STEPS_DEF  = 16;
  localparam int MUL_BITS          = 32;

  localparam logic [2:0] STS_X       = 3'd0;
  localparam logic [2:0] STS_Y       = 3'd1;
  localparam logic [2:0] STS_POSE    = 3'd2;
  localparam logic [2:0] STS_DUP     = 3'd3;
  localparam logic [2:0] STS_LMARK   = 3'd4;
  localparam logic [2:0] STS_BADLEN  = 3'd5;
  localparam logic [2:0] STS_UNKNOWN = 3'd6;
  localparam logic [2:0] STS_SHORT   = 3'd7;

  localparam logic [1:0] REG_X_ID     = 2'd0;
  localparam logic [1:0] REG_Y_ID     = 2'd1;
  localparam logic [1:0] REG_ANGLE_ID = 2'd2;
  localparam logic [1:0] REG_CONE_ID  = 2'd3;

  localparam logic [3:0] LEN_SHORT = 4'd4;
  localparam logic [3:0] LEN_LONG  = 4'd8;

  // angles in Q.32 radians, vectors in Q.30
  localparam logic signed [36:0] ANG_PI      = 37'sd13493037705;
  localparam logic signed [36:0] ANG_HALF_PI = 37'sd6746518852;
  localparam logic signed [36:0] ANG_TWO_PI  = 37'sd26986075409;
  localparam logic [49:0]        DIV_INIT    = 50'd26986075409 << 15;
  localparam logic [65:0]        DEG2RAD_Q32 = 66'd74961321;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;

  typedef enum logic [2:0] {
    S_IDLE, S_DEG, S_BRG, S_SUM, S_MOD, S_FOLD, S_ROT, S_MUL
  } pld_state_t;

  typedef struct packed {
    logic [31:0] frame_id;
    logic [3:0]  frame_len;
    logic [31:0] payload_lo;
    logic [31:0] payload_hi;
  } pld_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [7:0]         cone_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] range_out;
    logic signed [31:0] bearing_out;
    logic [15:0]        pose_index;
    logic               measurement_valid;
  } pld_out_t;

  // IEEE single to Q16.16, round half away from zero, saturating
  function automatic logic signed [31:0] float_to_q16(input logic [31:0] b);
    logic [7:0]  e;
    logic [31:0] mant;
    logic [31:0] mag;
    logic [4:0]  r;
    logic [2:0]  sh;
    e    = b[30:23];
    mant = {8'd0, 1'b1, b[22:0]};
    r    = 5'(8'd134 - e);
    sh   = 3'(e - 8'd134);
    mag  = '0;
    if (e == 8'd255) begin
      if (b[22:0] != '0) mag = '0;
      else return b[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (e == 8'd0 || e <= 8'd109) begin
      mag = '0;
    end else if (e >= 8'd142) begin
      return b[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else if (e >= 8'd134) begin
      mag = mant << sh;
    end else begin
      mag = (mant + (32'd1 << (r - 5'd1))) >> r;
    end
    return b[31] ? -$signed(mag) : $signed(mag);
  endfunction

  // atan(2^-i) in Q.32, rounded
  function automatic logic [31:0] atan_q32(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:    a = 32'd3373259426;
      5'd1:    a = 32'd1991351318;
      5'd2:    a = 32'd1052175346;
      5'd3:    a = 32'd534100635;
      5'd4:    a = 32'd268086748;
      5'd5:    a = 32'd134174063;
      5'd6:    a = 32'd67103403;
      5'd7:    a = 32'd33553749;
      5'd8:    a = 32'd16777131;
      5'd9:    a = 32'd8388597;
      5'd10:   a = 32'd4194303;
      default: a = 32'd1 << (6'd32 - {1'b0, i});
    endcase
    return a;
  endfunction

endpackage

[hw/rtl/pose_landmark_frame_decoder.sv]
// Pose and landmark frame decoder, top level.
// Depends on pld_pkg (types, status codes, float conversion, arctangent ROM).
//
// Usage: one received frame per input transfer (in_valid/in_stall, payload
// in_data), one result per frame on out_valid/out_stall (payload out_data).
// Frame identifiers are programmed through cfg_valid/cfg_ready/cfg_index/
// cfg_data; cfg_ready is always high and writes are expected while idle.
// Length, x, y, angle, unknown and short-cone frames finish in the accept
// cycle: the result is registered and shows in the next cycle, so such frames
// can follow one per cycle while the receiver takes them.
// A full cone frame runs serially: a shift-add multiply for the degree to
// radian product, the setup states S_BRG and S_SUM, restoring modulo 2*pi, a
// fold step, CORDIC_STEPS rotation steps, a shift-add multiply for the x and
// y projections and a load of the result register, which waits while the
// receiver stalls the output.
// One frame is in work at a time; the next is taken once the result
// register is free or being drained, so a stalled receiver holds off input.
// Synchronous active-low reset clears identifiers, latched pose and count.
module pose_landmark_frame_decoder #(
  parameter int CONE_WINDOW  = pld_pkg::CONE_WINDOW_DEF,
  parameter int CORDIC_STEPS = pld_pkg::CORDIC_STEPS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  pld_pkg::pld_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output pld_pkg::pld_out_t out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [31:0]      cfg_data
);
  import pld_pkg::*;

  pld_state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;

  logic [ID_W-1:0] x_id_r, y_id_r, ang_id_r, cone_id_r;
  logic signed [31:0] lat_x_r, lat_y_r, lat_hd_r, last_x_r, last_y_r, last_hd_r;
  logic [15:0] pose_cnt_r;

  logic [7:0]         cone_r;
  logic signed [31:0] rg_r, br_r;
  logic               bneg_r, aneg_r, flip_r, pneg_x_r, pneg_y_r;
  logic [31:0]        mpl_r;
  logic [65:0]        mcx_r, mcy_r, acx_r, acy_r;
  logic [48:0]        rem_r;
  logic [49:0]        div_r;
  logic signed [36:0] ang_r;
  logic signed [33:0] cx_r, cy_r;

  pld_out_t out_r;
  logic     out_valid_r;

  logic out_free, accept, last_cnt;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE) || !out_free;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  // ---- immediate decode ----
  logic [ID_W-1:0] fid, diff;
  logic len_ok, is_x, is_y, is_ang, in_win, dup, go_cone;
  logic signed [31:0] fv, bdeg;
  logic [15:0] cnt_new;
  pld_out_t imm;

  assign fid  = in_data.frame_id[ID_W-1:0];
  assign diff = fid - cone_id_r;
  assign fv   = float_to_q16(in_data.payload_lo);
  assign bdeg = float_to_q16(in_data.payload_hi);

  always_comb begin
    len_ok  = (in_data.frame_len == LEN_SHORT) || (in_data.frame_len == LEN_LONG);
    is_x    = fid == x_id_r;
    is_y    = !is_x && fid == y_id_r;
    is_ang  = !is_x && !is_y && fid == ang_id_r;
    in_win  = (fid >= cone_id_r) && (diff < ID_W'(CONE_WINDOW));
    dup     = (pose_cnt_r != '0) && lat_x_r == last_x_r && lat_y_r == last_y_r &&
              fv == last_hd_r;
    cnt_new = pose_cnt_r;
    if (len_ok && is_ang && !dup && pose_cnt_r != 16'hFFFF) cnt_new = pose_cnt_r + 16'd1;
    go_cone = len_ok && !is_x && !is_y && !is_ang && in_win &&
              in_data.frame_len == LEN_LONG;

    imm            = '0;
    imm.pose_index = (cnt_new != '0) ? cnt_new - 16'd1 : 16'd0;
    if (!len_ok) begin
      imm.status = STS_BADLEN;
    end else if (is_x || is_y || is_ang) begin
      imm.pos_x   = is_x ? fv : lat_x_r;
      imm.pos_y   = is_y ? fv : lat_y_r;
      imm.heading = is_ang ? fv : lat_hd_r;
      if (is_x)      imm.status = STS_X;
      else if (is_y) imm.status = STS_Y;
      else           imm.status = dup ? STS_DUP : STS_POSE;
    end else if (in_win) begin
      imm.status     = STS_SHORT;
      imm.cone_index = diff[7:0];
    end else begin
      imm.status = STS_UNKNOWN;
    end
  end

  // ---- state machine ----
  assign last_cnt = (state_r == S_ROT) ? (cnt_r == CNT_W'(CORDIC_STEPS - 1))
                  : (state_r == S_MOD) ? (cnt_r == CNT_W'(15))
                  : (cnt_r == CNT_W'(MUL_BITS - 1));

  logic mul_done;
  logic done_wait_r;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    mul_done  = 1'b0;
    unique case (state_r)
      S_IDLE: if (accept && go_cone) state_nxt = S_DEG;
      S_DEG:  if (last_cnt) state_nxt = S_BRG;
      S_BRG:  state_nxt = S_SUM;
      S_SUM:  state_nxt = S_MOD;
      S_MOD:  if (last_cnt) state_nxt = S_FOLD;
      S_FOLD: state_nxt = S_ROT;
      S_ROT:  if (last_cnt) state_nxt = S_MUL;
      S_MUL: begin
        mul_done = done_wait_r && out_free;
        if (mul_done) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // ---- datapath helpers ----
  logic [32:0]        sum_mag;
  logic signed [32:0] hsum;
  logic [26:0]        brmag;
  logic signed [36:0] r0, r1, r2, rem_s, atan_s;
  logic               fl;
  logic signed [33:0] cfin, sfin, shx, shy, cx_nxt, cy_nxt;
  logic [35:0]        rx, ry;
  logic signed [39:0] sx, sy;
  pld_out_t fin;

  always_comb begin
    hsum    = 33'(lat_hd_r) + 33'(br_r);
    sum_mag = hsum[32] ? 33'(-hsum) : 33'(hsum);
    brmag   = 27'((acx_r + (66'd1 << 31)) >> 32);

    rem_s = $signed({2'b00, rem_r[34:0]});
    r0 = (aneg_r && rem_r != '0) ? ANG_TWO_PI - rem_s : rem_s;
    r1 = (r0 > ANG_PI) ? r0 - ANG_TWO_PI : r0;
    fl = 1'b0;
    r2 = r1;
    if (r1 > ANG_HALF_PI) begin
      r2 = r1 - ANG_PI;
      fl = 1'b1;
    end else if (r1 < -ANG_HALF_PI) begin
      r2 = r1 + ANG_PI;
      fl = 1'b1;
    end

    atan_s = $signed({5'd0, atan_q32(cnt_r[4:0])});
    shx    = cx_r >>> cnt_r[4:0];
    shy    = cy_r >>> cnt_r[4:0];
    cx_nxt = (ang_r >= 0) ? cx_r - shy : cx_r + shy;
    cy_nxt = (ang_r >= 0) ? cy_r + shx : cy_r - shx;
    // sampled on the last rotation, so take the vector after that step
    cfin   = flip_r ? -cx_nxt : cx_nxt;
    sfin   = flip_r ? -cy_nxt : cy_nxt;

    rx = 36'((acx_r + (66'd1 << 29)) >> 30);
    ry = 36'((acy_r + (66'd1 << 29)) >> 30);
    sx = 40'(lat_x_r) + (pneg_x_r ? -$signed({4'd0, rx}) : $signed({4'd0, rx}));
    sy = 40'(lat_y_r) + (pneg_y_r ? -$signed({4'd0, ry}) : $signed({4'd0, ry}));

    fin            = '0;
    fin.status     = STS_LMARK;
    fin.cone_index = cone_r;
    fin.pos_x      = (sx > 40'sd2147483647) ? 32'sh7FFF_FFFF :
                     (sx < -40'sd2147483648) ? 32'sh8000_0000 : 32'(sx);
    fin.pos_y      = (sy > 40'sd2147483647) ? 32'sh7FFF_FFFF :
                     (sy < -40'sd2147483648) ? 32'sh8000_0000 : 32'(sy);
    fin.heading    = lat_hd_r;
    fin.range_out  = rg_r;
    fin.bearing_out = br_r;
    fin.pose_index = (pose_cnt_r != '0) ? pose_cnt_r - 16'd1 : 16'd0;
    fin.measurement_valid = pose_cnt_r != '0;
  end

  // ---- control registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_id_r      <= '0;
      y_id_r      <= '0;
      ang_id_r    <= '0;
      cone_id_r   <= '0;
      lat_x_r     <= '0;
      lat_y_r     <= '0;
      lat_hd_r    <= '0;
      last_x_r    <= '0;
      last_y_r    <= '0;
      last_hd_r   <= '0;
      pose_cnt_r  <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      done_wait_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_X_ID:     x_id_r    <= cfg_data[ID_W-1:0];
          REG_Y_ID:     y_id_r    <= cfg_data[ID_W-1:0];
          REG_ANGLE_ID: ang_id_r  <= cfg_data[ID_W-1:0];
          default:      cone_id_r <= cfg_data[ID_W-1:0];
        endcase
      end

      if (accept && len_ok) begin
        if (is_x) lat_x_r <= fv;
        if (is_y) lat_y_r <= fv;
        if (is_ang) begin
          lat_hd_r <= fv;
          if (!dup) begin
            last_x_r  <= lat_x_r;
            last_y_r  <= lat_y_r;
            last_hd_r <= fv;
          end
        end
      end
      pose_cnt_r <= accept ? cnt_new : pose_cnt_r;

      if ((accept && !go_cone) || mul_done) out_valid_r <= 1'b1;
      else if (!out_stall)                  out_valid_r <= 1'b0;

      if (state_r != state_nxt || state_r == S_BRG || state_r == S_SUM) cnt_r <= '0;
      else if (!(state_r == S_MUL && done_wait_r)) cnt_r <= cnt_r + CNT_W'(1);

      if (state_r == S_MUL && last_cnt && !done_wait_r) done_wait_r <= 1'b1;
      else if (mul_done)                                done_wait_r <= 1'b0;
    end
  end

  // ---- payload registers ----
  always_ff @(posedge clk) begin
    if (accept && !go_cone) out_r <= imm;
    else if (mul_done)      out_r <= fin;

    unique case (state_r)
      S_IDLE: begin
        cone_r <= diff[7:0];
        rg_r   <= fv;
        bneg_r <= bdeg[31];
        mpl_r  <= bdeg[31] ? 32'(-bdeg) : 32'(bdeg);
        mcx_r  <= DEG2RAD_Q32;
        acx_r  <= '0;
      end
      S_DEG, S_MUL: begin
        if (!done_wait_r) begin
          if (mpl_r[0]) begin
            acx_r <= acx_r + mcx_r;
            acy_r <= acy_r + mcy_r;
          end
          mpl_r <= mpl_r >> 1;
          mcx_r <= mcx_r << 1;
          mcy_r <= mcy_r << 1;
        end
      end
      S_BRG: begin
        br_r <= bneg_r ? -$signed({5'd0, brmag}) : $signed({5'd0, brmag});
      end
      S_SUM: begin
        aneg_r <= hsum[32];
        rem_r  <= {sum_mag, 16'd0};
        div_r  <= DIV_INIT;
      end
      S_MOD: begin
        if ({1'b0, rem_r} >= div_r) rem_r <= 49'({1'b0, rem_r} - div_r);
        div_r <= div_r >> 1;
      end
      S_FOLD: begin
        ang_r  <= r2;
        flip_r <= fl;
        cx_r   <= GAIN_Q30;
        cy_r   <= '0;
      end
      S_ROT: begin
        cx_r  <= cx_nxt;
        cy_r  <= cy_nxt;
        ang_r <= (ang_r >= 0) ? ang_r - atan_s : ang_r + atan_s;
        if (last_cnt) begin
          mpl_r    <= rg_r[31] ? 32'(-rg_r) : 32'(rg_r);
          mcx_r    <= 66'(cfin[33] ? -cfin : cfin);
          mcy_r    <= 66'(sfin[33] ? -sfin : sfin);
          acx_r    <= '0;
          acy_r    <= '0;
          pneg_x_r <= rg_r[31] ^ cfin[33];
          pneg_y_r <= rg_r[31] ^ sfin[33];
        end
      end
      default: ;
    endcase
  end

endmodule
